// ===== design/xcr_pkg.sv =====
// Shared types and constants for the XMODEM checksum receiver.
// Holds protocol characters, reset values, the command record passed
// from the front end to the result sequencer, and register indexes.
`timescale 1ns / 1ps
`default_nettype none

package xcr_pkg;

  // Protocol characters
  localparam logic [7:0] CH_SOH    = 8'h01;
  localparam logic [7:0] CH_EOT    = 8'h04;
  localparam logic [7:0] CH_ACK    = 8'h06;
  localparam logic [7:0] CH_NAK    = 8'h15;
  localparam logic [7:0] CH_CAN    = 8'h18;
  localparam logic [7:0] CH_G_UP   = 8'h47;
  localparam logic [7:0] CH_G_LOW  = 8'h67;

  // Register reset values
  localparam logic [31:0] RESET_NAK_TIMEOUT = 32'd4000000;
  localparam logic [31:0] RESET_LOAD_BASE   = 32'h0000_8000;

  // Defaults for top-level parameters
  localparam int DEF_BLOCK_BYTES = 128;
  localparam int DEF_QUEUE_DEPTH = 4;

  // A failure sends this many CANs and then one NAK.
  localparam int FAIL_CAN_BEATS = 5;
  localparam int BEAT_W         = $clog2(FAIL_CAN_BEATS + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAK_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE   = 1'b1;

  // Result beat packing: tx_valid, tx_byte, wr_valid, wr_addr, wr_data, go
  localparam int OUT_FIELDS_W = 51;
  localparam int OUT_TDATA_W  = 56;

  typedef enum logic [2:0] {
    OP_NAK,
    OP_ACK,
    OP_WR,
    OP_GO,
    OP_FAIL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [7:0]  data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/xcr_front.sv =====
// Front end of the XMODEM checksum receiver: accepts bytes and ticks,
// runs the packet checker and issues one command per item with results.
// Depends on xcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcr_front #(
  parameter int BLOCK_BYTES = xcr_pkg::DEF_BLOCK_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           item_valid,
  input  wire logic                           item_kind,
  input  wire logic [7:0]                     item_byte,
  input  wire logic                           cfg_we,
  input  wire logic [xcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output logic                                cmd_push,
  output xcr_pkg::cmd_t                       cmd
);
  import xcr_pkg::*;

  localparam int IDX_W = $clog2(BLOCK_BYTES);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HDR,
    PH_BLK,
    PH_INV,
    PH_DATA,
    PH_CSUM,
    PH_GO
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [7:0]         blk_r, blk_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [31:0]        wptr_r, wptr_nxt;
  logic [31:0]        tick_r, tick_nxt;
  logic [31:0]        timeout_r;
  logic [31:0]        base_r;
  logic [31:0]        tick_inc;

  assign tick_inc = (tick_r != '1) ? tick_r + 32'd1 : tick_r;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    blk_nxt   = blk_r;
    sum_nxt   = sum_r;
    wptr_nxt  = wptr_r;
    tick_nxt  = tick_r;
    cmd_push  = 1'b0;
    cmd.op    = OP_NAK;
    cmd.addr  = '0;
    cmd.data  = '0;

    if (item_valid) begin
      if (item_kind) begin
        if (phase_r == PH_WAIT) begin
          tick_nxt = tick_inc;
          if (tick_inc >= timeout_r) begin
            cmd_push = 1'b1;
            cmd.op   = OP_NAK;
            tick_nxt = '0;
          end
        end
      end else begin
        case (phase_r)
          PH_WAIT, PH_HDR: begin
            if (item_byte == CH_SOH) begin
              sum_nxt   = item_byte;
              phase_nxt = PH_BLK;
            end else if (item_byte == CH_EOT) begin
              cmd_push  = 1'b1;
              cmd.op    = OP_ACK;
              phase_nxt = PH_GO;
            end else begin
              cmd_push = 1'b1;
              cmd.op   = OP_FAIL;
            end
          end
          PH_BLK: begin
            if (item_byte == blk_r) begin
              sum_nxt   = sum_r + item_byte;
              phase_nxt = PH_INV;
            end else begin
              cmd_push = 1'b1;
              cmd.op   = OP_FAIL;
            end
          end
          PH_INV: begin
            if (item_byte == ~blk_r) begin
              sum_nxt   = sum_r + item_byte;
              idx_nxt   = '0;
              phase_nxt = PH_DATA;
            end else begin
              cmd_push = 1'b1;
              cmd.op   = OP_FAIL;
            end
          end
          PH_DATA: begin
            sum_nxt  = sum_r + item_byte;
            cmd_push = 1'b1;
            cmd.op   = OP_WR;
            cmd.addr = wptr_r + 32'(idx_r);
            cmd.data = item_byte;
            if (idx_r == IDX_W'(BLOCK_BYTES - 1)) begin
              idx_nxt   = '0;
              phase_nxt = PH_CSUM;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          PH_CSUM: begin
            if (item_byte == sum_r) begin
              cmd_push  = 1'b1;
              cmd.op    = OP_ACK;
              blk_nxt   = blk_r + 8'd1;
              wptr_nxt  = wptr_r + 32'(BLOCK_BYTES);
              phase_nxt = PH_HDR;
            end else begin
              cmd_push = 1'b1;
              cmd.op   = OP_FAIL;
            end
          end
          PH_GO: begin
            if (item_byte == CH_G_LOW || item_byte == CH_G_UP) begin
              cmd_push  = 1'b1;
              cmd.op    = OP_GO;
              idx_nxt   = '0;
              blk_nxt   = 8'd1;
              sum_nxt   = '0;
              wptr_nxt  = base_r;
              tick_nxt  = timeout_r - 32'd1;
              phase_nxt = PH_WAIT;
            end
          end
          default: begin
            phase_nxt = PH_WAIT;
          end
        endcase

        // Any failure restarts the transfer at base with the timer cleared.
        if (cmd_push && cmd.op == OP_FAIL) begin
          idx_nxt   = '0;
          blk_nxt   = 8'd1;
          sum_nxt   = '0;
          wptr_nxt  = base_r;
          tick_nxt  = '0;
          phase_nxt = PH_WAIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      idx_r     <= '0;
      blk_r     <= 8'd1;
      sum_r     <= '0;
      wptr_r    <= RESET_LOAD_BASE;
      tick_r    <= RESET_NAK_TIMEOUT - 32'd1;
      timeout_r <= RESET_NAK_TIMEOUT;
      base_r    <= RESET_LOAD_BASE;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      blk_r   <= blk_nxt;
      sum_r   <= sum_nxt;
      wptr_r  <= wptr_nxt;
      tick_r  <= tick_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NAK_TIMEOUT: timeout_r <= cfg_data;
          CFG_LOAD_BASE:   base_r    <= cfg_data;
          default:         timeout_r <= timeout_r;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/xcr_fifo.sv =====
// Command queue between the front end and the result sequencer.
// Small register array with read and write pointers. Depends on xcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcr_fifo #(
  parameter int DEPTH = xcr_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire xcr_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output xcr_pkg::cmd_t       head
);
  import xcr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/xcr_back.sv =====
// Result sequencer: expands queued commands into result beats and holds
// them in the output register. Depends on xcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcr_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_empty,
  input  wire xcr_pkg::cmd_t                   q_head,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [xcr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);
  import xcr_pkg::*;

  logic [BEAT_W-1:0]       beat_r, beat_nxt;
  logic                    valid_r;
  logic [OUT_TDATA_W-1:0]  data_r;
  logic                    last_r;
  logic                    load;

  logic                    b_txv, b_wrv, b_go, b_last;
  logic [7:0]              b_txb, b_wrd;
  logic [31:0]             b_addr;

  assign load  = !q_empty && (!valid_r || out_tready);
  assign q_pop = load && b_last;

  always_comb begin
    b_txv  = 1'b0;
    b_txb  = '0;
    b_wrv  = 1'b0;
    b_addr = '0;
    b_wrd  = '0;
    b_go   = 1'b0;
    b_last = 1'b1;
    case (q_head.op)
      OP_NAK: begin
        b_txv = 1'b1;
        b_txb = CH_NAK;
      end
      OP_ACK: begin
        b_txv = 1'b1;
        b_txb = CH_ACK;
      end
      OP_WR: begin
        b_wrv  = 1'b1;
        b_addr = q_head.addr;
        b_wrd  = q_head.data;
      end
      OP_GO: begin
        b_go = 1'b1;
      end
      OP_FAIL: begin
        b_txv = 1'b1;
        if (beat_r == BEAT_W'(FAIL_CAN_BEATS)) begin
          b_txb = CH_NAK;
        end else begin
          b_txb  = CH_CAN;
          b_last = 1'b0;
        end
      end
      default: begin
        b_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    beat_nxt = beat_r;
    if (load) begin
      beat_nxt = b_last ? '0 : beat_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), b_go, b_wrd, b_addr, b_wrv, b_txb, b_txv};
      last_r <= b_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else begin
      beat_r <= beat_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

`ifndef ASSERT_OFF
  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r <= BEAT_W'(FAIL_CAN_BEATS))
    else $error("failure burst counter out of range");

  a_write_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tlast && !out_tdata[0])
    else $error("memory write beat must be a single, final beat");

  a_inner_beat_is_can: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[0] && out_tdata[8:1] == CH_CAN)
    else $error("non-final beat must be a CAN");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r != '0 |-> !q_empty && q_head.op == OP_FAIL)
    else $error("failure burst lost its command");
`endif

endmodule

`default_nettype wire

// ===== design/xmodem_checksum_receiver.sv =====
// The first result beat of an item is held in the command queue and then in the output register before it is valid.
// Throughput: one item per cycle while the command queue has room; the output register holds one result beat
// at a time, so a failure (five CANs and a NAK) holds the result side for six result beats while the command
// queue of QUEUE_DEPTH entries lets the input side keep running until the queue fills.
// Reset (rst_n, synchronous, active low) clears control state, restores the registers to their
// defaults and preloads the tick counter so that the first tick sends the opening NAK.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the XMODEM checksum receiver: front end, command queue and
// result sequencer. Depends on xcr_pkg, xcr_front, xcr_fifo and xcr_back.
module xmodem_checksum_receiver #(
  parameter int BLOCK_BYTES = xcr_pkg::DEF_BLOCK_BYTES,
  parameter int QUEUE_DEPTH = xcr_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel: one beat is a received byte or a timer tick.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]                     in_tuser,   // [0] kind (1 = tick)
  // Result channel: each beat is one result; tlast marks the final result of an item.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] wr_valid, [41:10] wr_addr,
  // [49:42] wr_data, [50] go, [55:51] zero
  output logic [xcr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  // Configuration: index 0 is the NAK timeout in ticks, index 1 the load base address.
  input  wire logic                           cfg_we,
  input  wire logic [xcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import xcr_pkg::*;

  logic  accept;
  logic  cmd_push;
  cmd_t  cmd;
  logic  q_full, q_empty, q_pop;
  cmd_t  q_head;

  // Every item is taken while the queue has room; items that cause no result
  // simply push nothing.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Front end: packet checker, tick timer and configuration registers.
  xcr_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (accept),
    .item_kind  (in_tuser[0]),
    .item_byte  (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_push   (cmd_push),
    .cmd        (cmd)
  );

  // Queue of pending commands so either side can stall on its own.
  xcr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back end: turns each command into one or more result beats.
  xcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== test/xmodem_checksum_receiver_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the XMODEM checksum receiver: directed protocol cases, then
// random transfers under changing handshake pressure. Needs xcr_pkg and the receiver RTL.
module xmodem_checksum_receiver_tb;
  import xcr_pkg::*;

  localparam int BLOCK_LEN     = DEF_BLOCK_BYTES;
  // Cycles allowed after the last expected beat for anything still in flight.
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  // Number of accepted input beats between changes of the idle pattern.
  localparam int IDLE_STRETCH  = 24;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Receiver protocol phases as the prediction tracks them.
  typedef enum logic [2:0] {
    RX_WAIT, RX_HDR, RX_BLK, RX_INV, RX_DATA, RX_CSUM, RX_GO
  } rx_phase_e;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // One result beat as it is expected on the result channel.
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        wr_valid;
    logic [31:0] wr_addr;
    logic [7:0]  wr_data;
    logic        go;
    logic        last;
  } rx_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;   // [7:0] rx_byte
  logic [0:0]             in_tuser   = '0;   // [0] kind (1 = tick)
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] tx_valid, [8:1] tx_byte, [9] wr_valid, [41:10] wr_addr, [49:42] wr_data, [50] go
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [31:0]            cfg_data   = '0;

  xmodem_checksum_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Mirror of the receiver: its registers and protocol state, kept in step with every
  // accepted input beat. Results it predicts wait in pending_results until they arrive.
  logic [31:0] nak_timeout;
  logic [31:0] load_base;
  rx_phase_e   rx_phase;
  int unsigned data_offset;
  logic [7:0]  block_no;
  logic [7:0]  csum;
  logic [31:0] write_ptr;
  logic [31:0] tick_count;
  rx_result_t  pending_results[$];

  int unsigned errors        = 0;
  int unsigned beats_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count   = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  idle_mode_e  idle_mode      = IDLE_NONE;
  bit          rotate_idle    = 1'b0;

  // 2 ns clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Global watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // The result side stalls at random according to the current idle pattern.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void set_idle_mode(input idle_mode_e mode);
    idle_mode = mode;
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 61;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 61;
      end
      default: begin
        send_idle_pct  = 30;
        recv_stall_pct = 30;
      end
    endcase
  endfunction

  function automatic void push_result(input logic txv, input logic [7:0] txb,
                                      input logic wrv, input logic [31:0] addr,
                                      input logic [7:0] data, input logic go);
    rx_result_t r;
    r.tx_valid = txv;
    r.tx_byte  = txb;
    r.wr_valid = wrv;
    r.wr_addr  = addr;
    r.wr_data  = data;
    r.go       = go;
    r.last     = 1'b1;  // every case below ends its burst with exactly one such beat
    pending_results.push_back(r);
  endfunction

  function automatic void rewind_transfer();
    data_offset = 0;
    block_no    = 8'd1;
    csum        = 8'd0;
    write_ptr   = load_base;
  endfunction

  function automatic void reset_model();
    nak_timeout = RESET_NAK_TIMEOUT;
    load_base   = RESET_LOAD_BASE;
    rewind_transfer();
    rx_phase    = RX_WAIT;
    tick_count  = nak_timeout - 32'd1;
  endfunction

  // Any protocol error: five CANs, then a NAK, and the transfer starts over at the base.
  function automatic void abort_transfer();
    rx_result_t r;
    for (int k = 0; k < FAIL_CAN_BEATS; k++) begin
      push_result(1'b1, CH_CAN, 1'b0, 32'd0, 8'd0, 1'b0);
      r = pending_results.pop_back();
      r.last = 1'b0;
      pending_results.push_back(r);
    end
    push_result(1'b1, CH_NAK, 1'b0, 32'd0, 8'd0, 1'b0);
    rewind_transfer();
    rx_phase   = RX_WAIT;
    tick_count = 32'd0;
  endfunction

  // Advance the mirror by one accepted input beat and queue what it should produce.
  function automatic void predict_beat(input logic kind, input logic [7:0] value);
    if (kind == KIND_TICK) begin
      // Ticks only matter while waiting for the sender; the counter sticks at all ones.
      if (rx_phase == RX_WAIT) begin
        if (tick_count != '1) tick_count++;
        if (tick_count >= nak_timeout) begin
          push_result(1'b1, CH_NAK, 1'b0, 32'd0, 8'd0, 1'b0);
          tick_count = 32'd0;
        end
      end
    end else begin
      case (rx_phase)
        RX_WAIT, RX_HDR: begin
          if (value == CH_SOH) begin
            csum     = value;
            rx_phase = RX_BLK;
          end else if (value == CH_EOT) begin
            push_result(1'b1, CH_ACK, 1'b0, 32'd0, 8'd0, 1'b0);
            rx_phase = RX_GO;
          end else begin
            abort_transfer();
          end
        end
        RX_BLK: begin
          if (value == block_no) begin
            csum     = csum + value;
            rx_phase = RX_INV;
          end else begin
            abort_transfer();
          end
        end
        RX_INV: begin
          if (value == ~block_no) begin
            csum        = csum + value;
            data_offset = 0;
            rx_phase    = RX_DATA;
          end else begin
            abort_transfer();
          end
        end
        RX_DATA: begin
          csum = csum + value;
          push_result(1'b0, 8'd0, 1'b1, write_ptr + data_offset, value, 1'b0);
          data_offset++;
          if (data_offset >= BLOCK_LEN) begin
            data_offset = 0;
            rx_phase    = RX_CSUM;
          end
        end
        RX_CSUM: begin
          if (value == csum) begin
            push_result(1'b1, CH_ACK, 1'b0, 32'd0, 8'd0, 1'b0);
            block_no  = block_no + 8'd1;
            write_ptr = write_ptr + BLOCK_LEN;
            rx_phase  = RX_HDR;
          end else begin
            abort_transfer();
          end
        end
        RX_GO: begin
          // After EOT only a start command counts; other bytes pass without a trace.
          if (value == CH_G_LOW || value == CH_G_UP) begin
            push_result(1'b0, 8'd0, 1'b0, 32'd0, 8'd0, 1'b1);
            rewind_transfer();
            rx_phase   = RX_WAIT;
            tick_count = nak_timeout - 32'd1;
          end
        end
        default: rx_phase = RX_WAIT;
      endcase
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tlast %b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("tx_valid", want.tx_valid, out_tdata[0]);
        check_field("tx_byte",  want.tx_byte,  out_tdata[8:1]);
        check_field("wr_valid", want.wr_valid, out_tdata[9]);
        check_field("wr_addr",  want.wr_addr,  out_tdata[41:10]);
        check_field("wr_data",  want.wr_data,  out_tdata[49:42]);
        check_field("go",       want.go,       out_tdata[50]);
        check_field("last",     want.last,     out_tlast);
      end
    end
  end

  // Offers one beat and returns at the edge where it is accepted. The valid stays high
  // on return so that a following beat can go out back to back; whoever lets time pass
  // next either lowers it or replaces the payload in that same step.
  task automatic send_beat(input logic kind, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    predict_beat(kind, value);
    beats_sent++;
    if (rotate_idle && beats_sent % IDLE_STRETCH == 0)
      set_idle_mode(idle_mode_e'((idle_mode + 1) % 4));
  endtask

  // The data lines carry random bits on a tick; the receiver must ignore them.
  task automatic send_tick();
    send_beat(KIND_TICK, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_SOH || b == CH_EOT);
    return b;
  endfunction

  // Wait until every expected beat has come, plus time for work that shows no result.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_NAK_TIMEOUT) nak_timeout = value;
    else load_base = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] timeout, input logic [31:0] base);
    drain_results();
    write_register(CFG_NAK_TIMEOUT, timeout);
    write_register(CFG_LOAD_BASE, base);
    settings_used++;
  endtask

  // One complete packet with the expected header and random data; when corrupt is set
  // the checksum byte is off by a random nonzero pattern.
  task automatic send_packet(input logic corrupt);
    send_beat(KIND_BYTE, CH_SOH);
    send_beat(KIND_BYTE, block_no);
    send_beat(KIND_BYTE, ~block_no);
    repeat (BLOCK_LEN) send_beat(KIND_BYTE, 8'($urandom_range(255)));
    send_beat(KIND_BYTE, corrupt ? (csum ^ 8'($urandom_range(1, 255))) : csum);
  endtask

  // Default registers: the preloaded counter makes the first tick send NAK, later ticks
  // wait for the long timeout, EOT is ACKed, ticks and stray bytes after it do nothing,
  // and an upper-case start command reloads the counter for another immediate NAK.
  task automatic test_opening_nak();
    set_idle_mode(IDLE_NONE);
    send_tick();
    send_tick();
    send_tick();
    send_beat(KIND_BYTE, CH_EOT);
    send_tick();
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_BYTE, CH_G_UP);
    send_tick();
  endtask

  // Each way a header can go wrong aborts with CANs and a NAK: a junk first byte, a wrong
  // block number and a wrong inverted number. A timeout of one NAKs on every tick.
  task automatic test_header_errors();
    configure(32'd1, 32'd0);
    set_idle_mode(IDLE_BOTH);
    send_tick();
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, CH_SOH);
    send_beat(KIND_BYTE, 8'h02);
    send_beat(KIND_BYTE, CH_SOH);
    send_beat(KIND_BYTE, 8'h01);
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, 8'hFF);
    send_tick();
  endtask

  // Timeout of zero: every waiting tick NAKs. A start command before EOT is a header
  // error. After a lower-case start the counter reloads to all ones and the next tick NAKs.
  task automatic test_zero_timeout();
    configure(32'd0, 32'hFFFF_FFFF);
    set_idle_mode(IDLE_RECEIVER);
    send_tick();
    send_tick();
    send_beat(KIND_BYTE, CH_G_LOW);
    send_beat(KIND_BYTE, CH_EOT);
    send_beat(KIND_BYTE, CH_G_LOW);
    send_tick();
  endtask

  // One full packet, good or with a bad checksum, then packets and short cases until the
  // quota is met: broken headers, ticks, junk and EOT/start endings. A packet starts only
  // if the quota fits all but its checksum byte. The idle pattern rotates as beats go by.
  task automatic test_random_transfer(input logic [31:0] timeout, input logic [31:0] base,
                                      input int unsigned quota, input logic corrupt_first);
    int unsigned first;
    int unsigned pick;
    int unsigned room;
    logic [7:0]  b;
    configure(timeout, base);
    rotate_idle = 1'b1;
    first = beats_sent;
    // Restart the transfer so the new base address takes effect.
    if (rx_phase == RX_GO) send_beat(KIND_BYTE, CH_G_LOW);
    else send_beat(KIND_BYTE, noise_byte());
    send_packet(corrupt_first);
    while (beats_sent - first < quota) begin
      room = quota - (beats_sent - first);
      pick = $urandom_range(99);
      if (room < BLOCK_LEN + 3 && pick < 55) pick = $urandom_range(55, 99);
      if (rx_phase == RX_GO) begin
        if (pick < 25) send_tick();
        else if (pick < 50) send_beat(KIND_BYTE, 8'($urandom_range(255)));
        else send_beat(KIND_BYTE, pick[0] ? CH_G_UP : CH_G_LOW);
      end else if (pick < 45) begin
        send_packet(1'b0);
      end else if (pick < 55) begin
        send_packet(1'b1);
      end else if (pick < 62) begin
        do b = 8'($urandom_range(255)); while (b == block_no);
        send_beat(KIND_BYTE, CH_SOH);
        send_beat(KIND_BYTE, b);
      end else if (pick < 69) begin
        do b = 8'($urandom_range(255)); while (b == ~block_no);
        send_beat(KIND_BYTE, CH_SOH);
        send_beat(KIND_BYTE, block_no);
        send_beat(KIND_BYTE, b);
      end else if (pick < 77) begin
        send_beat(KIND_BYTE, CH_EOT);
      end else if (pick < 92 && rx_phase == RX_WAIT) begin
        repeat ($urandom_range(1, 4)) send_tick();
      end else begin
        send_beat(KIND_BYTE, noise_byte());
      end
    end
    rotate_idle = 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_opening_nak();
    test_header_errors();
    test_zero_timeout();
    // A base just below the top of the address space makes the first packet wrap.
    test_random_transfer(32'd3, 32'hFFFF_FFC0, 140, 1'b0);
    test_random_transfer(32'($urandom_range(2, 6)), 32'hFFFF_FFFF, 140, 1'b1);

    drain_results();
    $display("Sent %0d input beats and checked %0d result beats over %0d register settings,",
             beats_sent, results_seen, settings_used);
    $display("covering NAK timeouts, header and checksum errors, good packets, EOT and start.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
